// ----- design/mcst_pkg.sv -----
// Package for the multi-channel software timer.
// Holds the field widths, input kind codes, slot modes, controller states and
// the command struct that the controller broadcasts to every timer cell.
package mcst_pkg;

   localparam int KIND_W = 3;
   localparam int SLOT_W = 5;
   localparam int TIME_W = 32;
   localparam int DEFAULT_TIMER_SLOTS = 32;
   localparam logic [TIME_W-1:0] RELOAD_MIN = TIME_W'(1);

   // Input kinds. Codes 6 and 7 are ignored and fall into default arms.
   typedef enum logic [KIND_W-1:0] {
      KIND_CREATE = 3'd0,
      KIND_START  = 3'd1,
      KIND_STOP   = 3'd2,
      KIND_DELETE = 3'd3,
      KIND_QUERY  = 3'd4,
      KIND_TICK   = 3'd5
   } kind_type;

   // Per-slot life cycle.
   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_RUN    = 2'd1,
      MODE_UNUSED = 2'd2
   } mode_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_FLUSH = 2'd2
   } state_type;

   // Command broadcast from the controller to all cells.
   typedef struct packed {
      logic              apply;        // direct start, stop or delete this cycle
      kind_type          op;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] reload;       // already raised to the minimum
      logic [TIME_W-1:0] deadline;     // now plus reload, for start
      logic [TIME_W-1:0] now;
      logic              periodic;     // mode bit for the slot a create claims
      logic              scan_create;  // scan looks for an unused slot
      logic              advance;      // token moves one cell along the chain
      logic              clear;        // drop the token everywhere
   } cell_cmd_type;

   // What one cell reports back to the controller.
   typedef struct packed {
      logic hit;      // the token sits here and this slot is the one wanted
      logic sel_run;  // this slot is addressed and running
   } cell_report_type;

endpackage

// ----- design/mcst_channel_if.sv -----
// Handshake channels of the multi-channel software timer.
// One interface for request items and one for result items; uses mcst_pkg.
interface mcst_req_if;
   import mcst_pkg::*;
   logic                   valid;
   logic                   ready;
   logic [KIND_W-1:0]      kind;
   logic [SLOT_W-1:0]      slot;
   logic [TIME_W-1:0]      reload_ticks;
   logic                   periodic;

   modport source (output valid, kind, slot, reload_ticks, periodic, input ready);
   modport sink   (input valid, kind, slot, reload_ticks, periodic, output ready);
endinterface

interface mcst_rsp_if;
   import mcst_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   status;
   logic [SLOT_W-1:0]      result_slot;
   logic                   running;
   logic                   expired;
   logic                   last;

   modport source (output valid, status, result_slot, running, expired, last,
                   input ready);
   modport sink   (input valid, status, result_slot, running, expired, last,
                   output ready);
endinterface

// ----- design/mcst_cell.sv -----
// One timer cell of the chain: mode, periodic flag, deadline and reload of
// a single slot, plus the scan token handed on to the next cell. Uses mcst_pkg.
module mcst_cell
   import mcst_pkg::*;
#(
   parameter int CELL_INDEX = 0
) (
   input  logic            clock,
   input  logic            reset,
   input  cell_cmd_type    cmd,
   input  logic            tok_left,
   output logic            tok_out,
   output cell_report_type report
);

   localparam logic              IN_RANGE = CELL_INDEX < (1 << SLOT_W);
   localparam logic [SLOT_W-1:0] CELL_SLOT = SLOT_W'(CELL_INDEX);

   mode_type          mode_ff, mode_in;
   logic              periodic_ff, periodic_in;
   logic [TIME_W-1:0] deadline_ff, deadline_in;
   logic [TIME_W-1:0] reload_ff, reload_in;
   logic              tok_ff, tok_in;
   logic              match;
   logic              due;

   assign match = IN_RANGE && (cmd.slot == CELL_SLOT);
   assign due   = (mode_ff == MODE_RUN) && (cmd.now >= deadline_ff);

   assign tok_out        = tok_ff;
   assign report.hit     = tok_ff && (cmd.scan_create ? (mode_ff == MODE_UNUSED) : due);
   assign report.sel_run = match && (mode_ff == MODE_RUN);

   // Next state: direct commands by address, scan work where the token sits.
   always_comb begin
      mode_in     = mode_ff;
      periodic_in = periodic_ff;
      deadline_in = deadline_ff;
      reload_in   = reload_ff;

      if (cmd.apply && match) begin
         case (cmd.op)
            KIND_START: begin
               if (mode_ff != MODE_UNUSED) begin
                  reload_in   = cmd.reload;
                  deadline_in = cmd.deadline;
                  mode_in     = MODE_RUN;
               end
            end
            KIND_STOP: begin
               if (mode_ff != MODE_UNUSED) begin
                  mode_in = MODE_IDLE;
               end
            end
            KIND_DELETE: begin
               mode_in = MODE_UNUSED;
            end
            default: begin
            end
         endcase
      end

      if (cmd.advance && tok_ff) begin
         if (cmd.scan_create) begin
            if (mode_ff == MODE_UNUSED) begin
               mode_in     = MODE_IDLE;
               periodic_in = cmd.periodic;
            end
         end else if (due) begin
            if (periodic_ff) begin
               deadline_in = deadline_ff + reload_ff;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
      end

      if (cmd.clear) begin
         tok_in = 1'b0;
      end else if (cmd.advance) begin
         tok_in = tok_left;
      end else begin
         tok_in = tok_ff;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNUSED;
         tok_ff  <= 1'b0;
      end else begin
         mode_ff <= mode_in;
         tok_ff  <= tok_in;
      end
   end

   // Slot payload, written before it is ever read.
   always_ff @(posedge clock) begin
      periodic_ff <= periodic_in;
      deadline_ff <= deadline_in;
      reload_ff   <= reload_in;
   end

endmodule

// ----- design/multi_channel_software_timer.sv -----
// Multi-channel software timer: a bank of timer slots built as a chain of
// cells, with the controller, time counter and result register. Uses mcst_pkg,
// mcst_req_if, mcst_rsp_if and mcst_cell.
//
// Request items arrive on req_bus: create, start, stop, delete, query or tick.
// Result items leave on rsp_bus, each with last set on the final result of
// its request item. Start, stop, delete and query are done in the cycle the
// item is accepted; their result shows on rsp_bus in the next cycle.
// Create and tick pass a scan token along the cell chain, one cell per
// cycle unless a stall holds it. A tick keeps the input closed from the
// accepting cycle through the scan of every cell and a final flush step.
// It gives one result per expired slot in slot order, none if nothing expired.
// A create keeps the input closed while the token scans up to its first
// unused slot, or across every cell when the bank is full.
// A new request item is taken only when the controller is idle and the
// result register is empty or being emptied.
// When the receiver stalls, the result register holds its item and the scan
// token stops in place until the next expiry can be handed on.
// Reset clears the time counter, marks every slot unused, drops the token
// and empties the result register.
module multi_channel_software_timer
   import mcst_pkg::*;
#(
   parameter int TIMER_SLOTS = DEFAULT_TIMER_SLOTS
) (
   input  logic       clock,
   input  logic       reset,
   mcst_req_if.sink   req_bus,
   mcst_rsp_if.source rsp_bus
);

   localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TIMER_SLOTS - 1);

   state_type         state_ff, state_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic [IDX_W-1:0]  scan_idx_ff, scan_idx_in;
   logic              scan_create_ff, scan_create_in;
   logic              scan_per_ff, scan_per_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;

   logic              rsp_valid_ff;
   logic              rsp_status_ff, rsp_running_ff, rsp_expired_ff, rsp_last_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic              push;
   logic              push_status, push_running, push_expired, push_last;
   logic [SLOT_W-1:0] push_slot;

   logic              out_free;
   logic              accept;
   logic              inject;
   logic              any_hit;
   logic              any_run;
   logic              last_cell;
   logic              need_push;
   logic [TIME_W-1:0] reload_eff;
   logic [6:0]        idx_ext;
   logic [SLOT_W-1:0] idx_slot;
   kind_type          req_kind;

   cell_cmd_type      cmd;
   logic              tok_chain [0:TIMER_SLOTS];
   cell_report_type   reports   [0:TIMER_SLOTS-1];

   assign out_free   = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = (state_ff == ST_IDLE) && out_free;
   assign accept     = req_bus.valid && req_bus.ready;
   assign req_kind   = kind_type'(req_bus.kind);
   assign reload_eff = (req_bus.reload_ticks == '0) ? RELOAD_MIN : req_bus.reload_ticks;
   assign last_cell  = (scan_idx_ff == LAST_IDX);
   assign idx_ext    = 7'(scan_idx_ff);
   assign idx_slot   = idx_ext[SLOT_W-1:0];
   assign need_push  = any_hit && pend_valid_ff;

   // Gather the cell reports.
   always_comb begin
      any_hit = 1'b0;
      any_run = 1'b0;
      for (int i = 0; i < TIMER_SLOTS; i++) begin
         any_hit = any_hit | reports[i].hit;
         any_run = any_run | reports[i].sel_run;
      end
   end

   // Controller: next state, cell commands and result pushes.
   always_comb begin
      state_in       = state_ff;
      now_in         = now_ff;
      scan_idx_in    = scan_idx_ff;
      scan_create_in = scan_create_ff;
      scan_per_in    = scan_per_ff;
      pend_valid_in  = pend_valid_ff;
      pend_slot_in   = pend_slot_ff;

      inject       = 1'b0;
      push         = 1'b0;
      push_status  = 1'b0;
      push_slot    = '0;
      push_running = 1'b0;
      push_expired = 1'b0;
      push_last    = 1'b1;

      cmd             = '0;
      cmd.op          = req_kind;
      cmd.slot        = req_bus.slot;
      cmd.reload      = reload_eff;
      cmd.deadline    = now_ff + reload_eff;
      cmd.now         = now_ff;
      cmd.periodic    = scan_per_ff;
      cmd.scan_create = scan_create_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_kind)
                  KIND_CREATE: begin
                     inject         = 1'b1;
                     cmd.advance    = 1'b1;
                     scan_idx_in    = '0;
                     scan_create_in = 1'b1;
                     scan_per_in    = req_bus.periodic;
                     state_in       = ST_SCAN;
                  end
                  KIND_TICK: begin
                     inject         = 1'b1;
                     cmd.advance    = 1'b1;
                     now_in         = now_ff + TIME_W'(1);
                     scan_idx_in    = '0;
                     scan_create_in = 1'b0;
                     pend_valid_in  = 1'b0;
                     state_in       = ST_SCAN;
                  end
                  KIND_START, KIND_STOP, KIND_DELETE: begin
                     cmd.apply = 1'b1;
                     push      = 1'b1;
                  end
                  KIND_QUERY: begin
                     push         = 1'b1;
                     push_slot    = req_bus.slot;
                     push_running = any_run;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (scan_create_ff) begin
               // Claim the first unused slot, or report a full bank at the end.
               if (any_hit) begin
                  if (out_free) begin
                     cmd.advance = 1'b1;
                     cmd.clear   = 1'b1;
                     push        = 1'b1;
                     push_slot   = idx_slot;
                     state_in    = ST_IDLE;
                  end
               end else if (!last_cell || out_free) begin
                  cmd.advance = 1'b1;
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
                  if (last_cell) begin
                     push        = 1'b1;
                     push_status = 1'b1;
                     state_in    = ST_IDLE;
                  end
               end
            end else if (!(need_push && !out_free)) begin
               // One expiry stays pending so the final one can carry last.
               cmd.advance = 1'b1;
               scan_idx_in = scan_idx_ff + IDX_W'(1);
               if (any_hit) begin
                  pend_valid_in = 1'b1;
                  pend_slot_in  = idx_slot;
               end
               if (need_push) begin
                  push         = 1'b1;
                  push_slot    = pend_slot_ff;
                  push_expired = 1'b1;
                  push_last    = 1'b0;
               end
               if (last_cell) begin
                  state_in = ST_FLUSH;
               end
            end
         end

         ST_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_slot     = pend_slot_ff;
               push_expired  = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Cell chain: the token enters at cell zero and moves one cell per advance.
   assign tok_chain[0] = inject;

   for (genvar g = 0; g < TIMER_SLOTS; g++) begin : g_cell
      mcst_cell #(
         .CELL_INDEX(g)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .cmd      (cmd),
         .tok_left (tok_chain[g]),
         .tok_out  (tok_chain[g+1]),
         .report   (reports[g])
      );
   end

   // Controller state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         now_ff        <= '0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         now_ff        <= now_in;
         pend_valid_ff <= pend_valid_in;
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Scan bookkeeping and result payload.
   always_ff @(posedge clock) begin
      scan_idx_ff    <= scan_idx_in;
      scan_create_ff <= scan_create_in;
      scan_per_ff    <= scan_per_in;
      pend_slot_ff   <= pend_slot_in;
      if (push) begin
         rsp_status_ff  <= push_status;
         rsp_slot_ff    <= push_slot;
         rsp_running_ff <= push_running;
         rsp_expired_ff <= push_expired;
         rsp_last_ff    <= push_last;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.result_slot = rsp_slot_ff;
   assign rsp_bus.running     = rsp_running_ff;
   assign rsp_bus.expired     = rsp_expired_ff;
   assign rsp_bus.last        = rsp_last_ff;

endmodule
